FILE: sv/rpn_stack_calculator_macros.svh
// Assertion macros shared by the rpn_stack_calculator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// Condition that holds on every clock edge outside reset.
`define RSC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Same-cycle implication.
`define RSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rsc_pkg.sv
// Shared types and constants for the RPN stack calculator.
// No dependencies; used by every module of the block.
package rsc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    // Fixed port field widths
    localparam int MODE_W      = 4;
    localparam int OPERAND_W   = 32;
    localparam int TOP_W       = 32;
    localparam int DEPTH_W     = 7;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 4;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;
    localparam int M_PAD_W     = M_TDATA_W - TOP_W - DEPTH_W;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_DROP  = 4'd5,
        OP_CLEAR = 4'd6,
        OP_SWAP  = 4'd7,
        OP_DUP   = 4'd8,
        OP_PEEK  = 4'd9
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ITER,
        S_WB1,
        S_WB2,
        S_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic latch_status;
        logic start_ser;
        logic wr_first;
        logic wr_second;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic err;
        logic serial;
        logic two_writes;
        logic ser_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: sv/rpn_stack_calculator.sv
// RPN stack calculator: one command in, one result out per command.
// Slave stream: tuser = mode (opcode), tdata = operand (used by push only).
// Master stream: tdata = top value, depth; tuser = status (ok, underflow,
// overflow, divide by zero). A failing command leaves the stack untouched.
// Commands are handled one at a time. After the input transfer each command
// is checked; a failing command goes straight to the result. Push, add, sub
// and the stack operations then write back once, swap twice (two writes on the
// single memory write port), and mul and div write back once after the
// bit-serial unit, doing one bit per cycle. A new command is taken in the
// cycle after the result is loaded, not before.
// The result sits in an output register: the next command is accepted and
// worked on while it waits, and only its own result load waits for the
// receiver to take the previous one.
// Reset (synchronous) empties the stack and drops any held result; the stack
// memory itself is not cleared and needs no sweep.
// Depends on rsc_pkg, rsc_ctrl, rsc_dpath.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = rsc_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [rsc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // [31:0] operand
    input  logic [rsc_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,  // [3:0] mode
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [rsc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,  // [31:0] top_value, [38:32] depth
    output logic [rsc_pkg::M_TUSER_W-1:0]   o_m_axis_tuser   // [1:0] status
);

    rsc_pkg::t_dp_cmd             cmd;
    rsc_pkg::t_dp_stat            stat;
    logic [rsc_pkg::TOP_W-1:0]    top_value;
    logic [rsc_pkg::DEPTH_W-1:0]  depth;
    logic [rsc_pkg::STATUS_W-1:0] status;

    rsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    rsc_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_s_axis_tuser[rsc_pkg::MODE_W-1:0]),
        .i_operand   ($signed(i_s_axis_tdata[rsc_pkg::OPERAND_W-1:0])),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_top_value (top_value),
        .o_depth     (depth),
        .o_status    (status)
    );

    assign o_m_axis_tdata = {{rsc_pkg::M_PAD_W{1'b0}}, depth, top_value};
    assign o_m_axis_tuser = status;

endmodule

FILE: sv/rsc_seru.sv
// Bit-serial multiply / signed divide unit, one bit per cycle.
// Depends on rsc_pkg for default widths.
module rsc_seru #(
    parameter int DATA_WIDTH = rsc_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_div,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic                  o_last
);

    localparam int NW = $clog2(DATA_WIDTH + 1);

    logic [NW-1:0]         r_cnt;
    logic                  r_div;
    logic                  r_neg;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_x;
    logic [DATA_WIDTH-1:0] r_y;

    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;

    // magnitude of the most negative value wraps onto itself, read as unsigned
    assign a_mag  = i_a[DATA_WIDTH-1] ? ('0 - i_a) : i_a;
    assign b_mag  = i_b[DATA_WIDTH-1] ? ('0 - i_b) : i_b;
    assign rem_sh = {r_acc, r_x[DATA_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= NW'(DATA_WIDTH);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_neg <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
            r_acc <= '0;
            r_x   <= i_div ? a_mag : i_a;
            r_y   <= i_div ? b_mag : i_b;
        end else if (r_cnt != '0) begin
            if (r_div) begin
                // restoring step: r_acc is the remainder, r_x shifts dividend out, quotient in
                if (!diff[DATA_WIDTH]) begin
                    r_acc <= diff[DATA_WIDTH-1:0];
                    r_x   <= {r_x[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    r_acc <= rem_sh[DATA_WIDTH-1:0];
                    r_x   <= {r_x[DATA_WIDTH-2:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[DATA_WIDTH-2:0], 1'b0};
                r_y <= {1'b0, r_y[DATA_WIDTH-1:1]};
            end
        end
    end

    assign o_result = r_div ? (r_neg ? ('0 - r_x) : r_x) : r_acc;
    assign o_last   = (r_cnt == NW'(1));

endmodule

FILE: sv/rsc_dpath.sv
// Datapath: stack memory, depth counter, operand registers, add/sub and result register.
// Depends on rsc_pkg, rsc_seru and rpn_stack_calculator_macros.svh.
`include "rpn_stack_calculator_macros.svh"

module rsc_dpath #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = rsc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rsc_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [rsc_pkg::OPERAND_W-1:0] i_operand,
    input  rsc_pkg::t_dp_cmd                    i_cmd,
    output rsc_pkg::t_dp_stat                   o_stat,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [rsc_pkg::TOP_W-1:0]           o_top_value,
    output logic [rsc_pkg::DEPTH_W-1:0]         o_depth,
    output logic [rsc_pkg::STATUS_W-1:0]        o_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

    rsc_pkg::t_op          r_mode;
    logic [DATA_WIDTH-1:0] r_opnd;
    logic [DATA_WIDTH-1:0] r_t;
    logic [DATA_WIDTH-1:0] r_s;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    rsc_pkg::t_status      r_status;
    rsc_pkg::t_status      chk_status;

    logic                        r_ovalid;
    logic [rsc_pkg::TOP_W-1:0]   r_otop;
    logic [rsc_pkg::DEPTH_W-1:0] r_odepth;
    rsc_pkg::t_status            r_ostatus;

    logic [CW-1:0]         cnt_m1;
    logic [CW-1:0]         cnt_m2;
    logic [AW-1:0]         a_new;
    logic [AW-1:0]         a_top;
    logic [AW-1:0]         a_sec;
    logic [1:0]            need;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] ser_res;
    logic                  ser_last;
    logic [DATA_WIDTH-1:0] alu_res;
    logic [DATA_WIDTH-1:0] new_top;
    logic                  out_free;

    assign cnt_m1 = r_count - 1'b1;
    assign cnt_m2 = r_count - CW'(2);
    assign a_new  = r_count[AW-1:0];
    assign a_top  = cnt_m1[AW-1:0];
    assign a_sec  = cnt_m2[AW-1:0];

    // Top and second are fetched at the input transfer; they stay put for the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= rsc_pkg::t_op'(i_mode);
            r_opnd <= DATA_WIDTH'(i_operand);
            r_t    <= mem[a_top];
            r_s    <= mem[a_sec];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        unique case (r_mode) inside
            rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL, rsc_pkg::OP_DIV,
            rsc_pkg::OP_SWAP:                                      need = 2'd2;
            rsc_pkg::OP_DROP, rsc_pkg::OP_DUP, rsc_pkg::OP_PEEK:   need = 2'd1;
            default:                                               need = 2'd0;
        endcase
    end

    // underflow wins over overflow and divide by zero
    always_comb begin
        if (r_count < CW'(need)) begin
            chk_status = rsc_pkg::ST_UNDER;
        end else if ((r_mode == rsc_pkg::OP_PUSH || r_mode == rsc_pkg::OP_DUP)
                     && r_count >= CW'(STACK_DEPTH)) begin
            chk_status = rsc_pkg::ST_OVER;
        end else if (r_mode == rsc_pkg::OP_DIV && r_t == '0) begin
            chk_status = rsc_pkg::ST_DIVZ;
        end else begin
            chk_status = rsc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_status) begin
            r_status <= chk_status;
        end
    end

    rsc_seru #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seru (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start_ser),
        .i_div    (r_mode == rsc_pkg::OP_DIV),
        .i_a      (r_s),
        .i_b      (r_t),
        .o_result (ser_res),
        .o_last   (ser_last)
    );

    always_comb begin
        case (r_mode)
            rsc_pkg::OP_ADD: alu_res = r_s + r_t;
            rsc_pkg::OP_SUB: alu_res = r_s - r_t;
            default:         alu_res = ser_res;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = a_new;
        wr_data = r_opnd;
        n_count = r_count;
        if (i_cmd.wr_first) begin
            unique case (r_mode) inside
                rsc_pkg::OP_PUSH: begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
                rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL, rsc_pkg::OP_DIV: begin
                    wr_en   = 1'b1;
                    wr_addr = a_sec;
                    wr_data = alu_res;
                    n_count = cnt_m1;
                end
                rsc_pkg::OP_DROP:  n_count = cnt_m1;
                rsc_pkg::OP_CLEAR: n_count = '0;
                rsc_pkg::OP_SWAP: begin
                    wr_en   = 1'b1;
                    wr_addr = a_top;
                    wr_data = r_s;
                end
                rsc_pkg::OP_DUP: begin
                    wr_en   = 1'b1;
                    wr_data = r_t;
                    n_count = r_count + 1'b1;
                end
                default: ;
            endcase
        end else if (i_cmd.wr_second) begin
            // second half of a swap
            wr_en   = 1'b1;
            wr_addr = a_sec;
            wr_data = r_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // new top, formed after the count has been updated
    always_comb begin
        if (r_count == '0) begin
            new_top = '0;
        end else if (r_status != rsc_pkg::ST_OK) begin
            new_top = r_t;
        end else begin
            case (r_mode)
                rsc_pkg::OP_PUSH: new_top = r_opnd;
                rsc_pkg::OP_ADD,
                rsc_pkg::OP_SUB,
                rsc_pkg::OP_MUL,
                rsc_pkg::OP_DIV:  new_top = alu_res;
                rsc_pkg::OP_DROP,
                rsc_pkg::OP_SWAP: new_top = r_s;
                default:          new_top = r_t;
            endcase
        end
    end

    assign out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_otop    <= rsc_pkg::TOP_W'(new_top);
            r_odepth  <= rsc_pkg::DEPTH_W'(r_count);
            r_ostatus <= r_status;
        end
    end

    assign o_m_tvalid  = r_ovalid;
    assign o_top_value = r_otop;
    assign o_depth     = r_odepth;
    assign o_status    = r_ostatus;

    assign o_stat.err        = (chk_status != rsc_pkg::ST_OK);
    assign o_stat.serial     = (r_mode == rsc_pkg::OP_MUL) || (r_mode == rsc_pkg::OP_DIV);
    assign o_stat.two_writes = (r_mode == rsc_pkg::OP_SWAP);
    assign o_stat.ser_last   = ser_last;
    assign o_stat.out_free   = out_free;

    `RSC_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(STACK_DEPTH), "stack count beyond depth")
    `RSC_ASSERT_IMPL(a_no_write_on_error, i_clk, i_rst_n, i_cmd.wr_first || i_cmd.wr_second, r_status == rsc_pkg::ST_OK, "stack written on failing item")
    `RSC_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_cmd.wr_first && r_mode == rsc_pkg::OP_PUSH, r_count == $past(r_count) + 1'b1, "push did not grow stack")
    `RSC_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_cmd.load_out, !r_ovalid || i_m_tready, "result overwritten while held")

endmodule

FILE: sv/rsc_ctrl.sv
// Controller state machine sequencing fetch, check, serial op, write-back and result.
// Depends on rsc_pkg.
module rsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output rsc_pkg::t_dp_cmd  o_cmd,
    input  rsc_pkg::t_dp_stat i_stat
);

    rsc_pkg::t_state r_state;
    rsc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            rsc_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = rsc_pkg::S_EXEC;
                end
            end
            rsc_pkg::S_EXEC: begin
                o_cmd.latch_status = 1'b1;
                if (i_stat.err) begin
                    n_state = rsc_pkg::S_RESP;
                end else if (i_stat.serial) begin
                    o_cmd.start_ser = 1'b1;
                    n_state         = rsc_pkg::S_ITER;
                end else begin
                    n_state = rsc_pkg::S_WB1;
                end
            end
            rsc_pkg::S_ITER: begin
                if (i_stat.ser_last) begin
                    n_state = rsc_pkg::S_WB1;
                end
            end
            rsc_pkg::S_WB1: begin
                o_cmd.wr_first = 1'b1;
                n_state = i_stat.two_writes ? rsc_pkg::S_WB2 : rsc_pkg::S_RESP;
            end
            rsc_pkg::S_WB2: begin
                o_cmd.wr_second = 1'b1;
                n_state         = rsc_pkg::S_RESP;
            end
            rsc_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = rsc_pkg::S_IDLE;
                end
            end
            default: n_state = rsc_pkg::S_IDLE;
        endcase
    end

endmodule
